// ----- rtl/ucdl_pkg.sv -----
package ucdl_pkg;

  // One descriptor byte as it arrives.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } in_item_t;

  // The summary of one descriptor set.
  typedef struct packed {
    logic        intf_found;
    logic [15:0] intf_offset;
    logic        alt_found;
    logic [7:0]  extra_alt_count;
    logic        ep_index_found;
    logic [15:0] ep_index_offset;
    logic        ep_addr_found;
    logic [15:0] ep_addr_offset;
    logic        malformed;
  } out_item_t;

  // A byte tagged with its offset, handed from the front to the walker.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic [15:0] offset;
  } tagged_byte_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_TARGET_INTF  = 2'd0;
  localparam logic [1:0] REG_TARGET_ALT   = 2'd1;
  localparam logic [1:0] REG_TARGET_EPIDX = 2'd2;
  localparam logic [1:0] REG_TARGET_EPADR = 2'd3;

  // Descriptor type codes.
  localparam logic [7:0] DESC_INTERFACE = 8'd4;
  localparam logic [7:0] DESC_ENDPOINT  = 8'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int RESULT_DEPTH = 2;

endpackage

// ----- rtl/ucdl_front.sv -----
module ucdl_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  ucdl_pkg::in_item_t     in_item,
  output logic                   q_valid,
  input  logic                   q_ready,
  output ucdl_pkg::tagged_byte_t q_item
);

  localparam int AW = $clog2(ucdl_pkg::QUEUE_DEPTH);

  ucdl_pkg::tagged_byte_t mem [ucdl_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic [15:0]   byte_offset;
  logic [15:0]   cur_offset;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (AW+1)'(ucdl_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign q_valid = (count != '0);
  assign do_pop  = q_valid && q_ready;
  assign q_item  = mem[rd_ptr];

  // A first byte restarts the offset at zero.
  assign cur_offset = in_item.first ? 16'd0 : byte_offset;

  // Offset counter, saturating.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
    end else if (do_push) begin
      byte_offset <= (cur_offset == 16'hFFFF) ? cur_offset : cur_offset + 16'd1;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= '{data_byte: in_item.data_byte, first: in_item.first,
                       offset: cur_offset};
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop) rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  // The queue never overflows or underflows.
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    full |-> !do_push) else $error("queue overflow");
  a_cnt_rng: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(ucdl_pkg::QUEUE_DEPTH)) else $error("queue count out of range");
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    do_pop |-> count != '0) else $error("pop from empty queue");

endmodule

// ----- rtl/ucdl_walker.sv -----
module ucdl_walker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             target_interface,
  input  logic [7:0]             target_alt,
  input  logic [7:0]             target_ep_index,
  input  logic [7:0]             target_ep_address,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  ucdl_pkg::tagged_byte_t q_item,
  output logic                   empty,
  input  logic                   pop,
  output ucdl_pkg::out_item_t    out_item
);

  typedef enum logic [1:0] {PH_SEEK, PH_RUN, PH_DONE} phase_t;

  localparam int RAW = $clog2(ucdl_pkg::RESULT_DEPTH);

  // Walk state.
  logic [15:0] total_length, next_desc_start, cur_desc_start, found_intf_offset;
  logic [7:0]  cur_desc_type, cur_intf_number, cur_len, cur_alt;
  logic [7:0]  intf_endpoint_count, endpoints_seen, alt_counter;
  logic        f_intf, f_alt, f_epidx, f_epaddr, f_malf, walk_on;
  logic [15:0] ep_off0, ep_off1;
  phase_t      phase;

  // Working copies for the current byte.
  logic [15:0] tl_n, nds_n, cds_n, fio_n, e0_n, e1_n;
  logic [7:0]  cdt_n, cin_n, cl_n, ca_n, iec_n, es_n, ac_n;
  logic        fi_n, fa_n, fe_n, fd_n, fm_n, wo_n;
  phase_t      ph_n;
  logic [15:0] o, r, last;
  logic [7:0]  b;
  logic [16:0] nx;
  logic        go_intf, emit;
  ucdl_pkg::out_item_t res;

  // Result queue.
  ucdl_pkg::out_item_t rq [ucdl_pkg::RESULT_DEPTH];
  logic [RAW-1:0] rq_wr, rq_rd;
  logic [RAW:0]   rq_cnt;
  logic           accept, rq_pop;

  assign rq_pop  = !empty && pop;
  assign empty   = (rq_cnt == '0);
  assign q_ready = (rq_cnt != (RAW+1)'(ucdl_pkg::RESULT_DEPTH)) || rq_pop;
  assign accept  = q_valid && q_ready;
  assign out_item = rq[rq_rd];

  // Per-byte walk of the descriptor chain.
  always_comb begin
    b = q_item.data_byte;
    o = q_item.offset;
    if (q_item.first) begin
      tl_n = '0; nds_n = '0; cds_n = '0; fio_n = '0; e0_n = '0; e1_n = '0;
      cdt_n = '0; cin_n = '0; cl_n = '0; ca_n = '0; iec_n = '0; es_n = '0; ac_n = '0;
      fi_n = 1'b0; fa_n = 1'b0; fe_n = 1'b0; fd_n = 1'b0; fm_n = 1'b0; wo_n = 1'b1;
      ph_n = PH_SEEK;
    end else begin
      tl_n = total_length; nds_n = next_desc_start; cds_n = cur_desc_start;
      fio_n = found_intf_offset; e0_n = ep_off0; e1_n = ep_off1;
      cdt_n = cur_desc_type; cin_n = cur_intf_number; cl_n = cur_len; ca_n = cur_alt;
      iec_n = intf_endpoint_count; es_n = endpoints_seen; ac_n = alt_counter;
      fi_n = f_intf; fa_n = f_alt; fe_n = f_epidx; fd_n = f_epaddr; fm_n = f_malf;
      wo_n = walk_on; ph_n = phase;
    end
    if (o == 16'd2) tl_n[7:0] = b;
    if (o == 16'd3) tl_n[15:8] = b;
    r  = o - cds_n;
    nx = {1'b0, o} + {9'd0, b};
    go_intf = 1'b0;
    if (wo_n) begin
      if (o == nds_n) begin
        if (o != 16'd0 && (o < 16'd4 || o >= tl_n)) begin
          wo_n = 1'b0;
        end else if (b == 8'd0) begin
          fm_n = 1'b1;
          wo_n = 1'b0;
        end else begin
          cds_n = o;
          cl_n  = b;
          cdt_n = '0;
          nds_n = nx[16] ? 16'hFFFF : nx[15:0];
        end
      end else if (o >= cds_n && r < {8'd0, cl_n}) begin
        if (r == 16'd1) begin
          cdt_n = b;
        end else if (cds_n != 16'd0) begin
          if (cdt_n == ucdl_pkg::DESC_INTERFACE) begin
            if (r == 16'd2) cin_n = b;
            else if (r == 16'd3) ca_n = b;
            else if (r == 16'd4) go_intf = 1'b1;
          end else if (cdt_n == ucdl_pkg::DESC_ENDPOINT && r == 16'd2) begin
            // Endpoint within the found interface's count.
            if (fi_n && es_n < iec_n) begin
              if (es_n == target_ep_index) begin
                fe_n = 1'b1;
                e0_n = cds_n;
              end
              if (!fd_n && b == target_ep_address) begin
                fd_n = 1'b1;
                e1_n = cds_n;
              end
              es_n = es_n + 8'd1;
            end
          end
        end
      end
    end
    // Interface descriptor complete.
    if (go_intf) begin
      unique case (ph_n)
        PH_SEEK: if (cin_n == target_interface) ph_n = PH_RUN;
                 else go_intf = 1'b0;
        PH_RUN:  if (cin_n != target_interface) begin
                   ph_n = PH_DONE;
                   go_intf = 1'b0;
                 end
        default: go_intf = 1'b0;
      endcase
      if (go_intf) begin
        if (!fi_n && ca_n == target_alt) begin
          fi_n  = 1'b1;
          fio_n = cds_n;
          iec_n = b;
          es_n  = '0;
        end
        if (fa_n) begin
          if (ac_n != 8'hFF) ac_n = ac_n + 8'd1;
        end else if (ca_n == 8'd0) begin
          fa_n = 1'b1;
        end
      end
    end
    last = (tl_n >= 16'd4) ? tl_n - 16'd1 : 16'd3;
    emit = (o >= 16'd3) && (o == last);
    res.intf_found      = fi_n;
    res.intf_offset     = fi_n ? fio_n : 16'd0;
    res.alt_found       = fa_n;
    res.extra_alt_count = fa_n ? ac_n : 8'd0;
    res.ep_index_found  = fe_n;
    res.ep_index_offset = fe_n ? e0_n : 16'd0;
    res.ep_addr_found   = fd_n;
    res.ep_addr_offset  = fd_n ? e1_n : 16'd0;
    res.malformed       = fm_n;
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= '0; next_desc_start <= '0; cur_desc_start <= '0;
      found_intf_offset <= '0; ep_off0 <= '0; ep_off1 <= '0;
      cur_desc_type <= '0; cur_intf_number <= '0; cur_len <= '0; cur_alt <= '0;
      intf_endpoint_count <= '0; endpoints_seen <= '0; alt_counter <= '0;
      f_intf <= 1'b0; f_alt <= 1'b0; f_epidx <= 1'b0; f_epaddr <= 1'b0;
      f_malf <= 1'b0; walk_on <= 1'b1; phase <= PH_SEEK;
    end else if (accept) begin
      total_length <= tl_n; next_desc_start <= nds_n; cur_desc_start <= cds_n;
      found_intf_offset <= fio_n; ep_off0 <= e0_n; ep_off1 <= e1_n;
      cur_desc_type <= cdt_n; cur_intf_number <= cin_n; cur_len <= cl_n;
      cur_alt <= ca_n; intf_endpoint_count <= iec_n; endpoints_seen <= es_n;
      alt_counter <= ac_n; f_intf <= fi_n; f_alt <= fa_n; f_epidx <= fe_n;
      f_epaddr <= fd_n; f_malf <= fm_n; walk_on <= wo_n; phase <= ph_n;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (accept && emit) rq[rq_wr] <= res;
  end

  // Result queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr <= '0; rq_rd <= '0; rq_cnt <= '0;
    end else begin
      if (accept && emit) rq_wr <= rq_wr + RAW'(1);
      if (rq_pop) rq_rd <= rq_rd + RAW'(1);
      rq_cnt <= rq_cnt + (RAW+1)'(accept && emit) - (RAW+1)'(rq_pop);
    end
  end

  // Endpoint counting never exceeds the interface's endpoint count.
  a_es: assert property (@(posedge clk) disable iff (rst)
    f_intf |-> endpoints_seen <= intf_endpoint_count) else $error("endpoint overcount");
  a_ep: assert property (@(posedge clk) disable iff (rst)
    (f_epidx || f_epaddr) |-> f_intf) else $error("endpoint without interface");
  a_rq: assert property (@(posedge clk) disable iff (rst)
    rq_cnt <= (RAW+1)'(ucdl_pkg::RESULT_DEPTH)) else $error("result queue overflow");

endmodule

// ----- rtl/usb_config_descriptor_locator_core.sv -----
// Channel | Handshake            | Payload
// input   | push / full          | in_item (data_byte, first)
// result  | pop / empty          | out_item (summary)
// config  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One byte a cycle while the walker is not stalled; a byte is registered in the front queue, then in the walker.
// The walker's combinational compare and registered update of the chain state sets the rate.
// rst is synchronous and active high; it clears targets, walk state and both queues.
// A full result queue stalls the walker, and a full byte queue raises full.
module usb_config_descriptor_locator_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ucdl_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output ucdl_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  logic [7:0] target_interface, target_alt, target_ep_index, target_ep_address;
  logic                   q_valid, q_ready;
  ucdl_pkg::tagged_byte_t q_item;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_interface <= '0; target_alt <= '0;
      target_ep_index <= '0; target_ep_address <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ucdl_pkg::REG_TARGET_INTF:  target_interface  <= cfg_data;
        ucdl_pkg::REG_TARGET_ALT:   target_alt        <= cfg_data;
        ucdl_pkg::REG_TARGET_EPIDX: target_ep_index   <= cfg_data;
        ucdl_pkg::REG_TARGET_EPADR: target_ep_address <= cfg_data;
      endcase
    end
  end

  ucdl_front u_front (
    .clk, .rst, .push, .full, .in_item, .q_valid, .q_ready, .q_item
  );

  ucdl_walker u_walker (
    .clk, .rst, .target_interface, .target_alt, .target_ep_index,
    .target_ep_address, .q_valid, .q_ready, .q_item, .empty, .pop, .out_item
  );

endmodule
